// ----- rtl/amre_pkg.sv -----
// Shared types and constants for the alpha mask run extractor.
// Used by the front, queue, back and top-level modules; no dependencies.
`timescale 1ns / 1ps

package amre_pkg;

  localparam int RECT_W    = 13;
  localparam int COUNT_W   = 24;
  localparam int CFG_IDX_W = 2;
  localparam int ALPHA_W   = 8;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam logic [RECT_W-1:0] CFG_WIDTH_RESET  = 13'd640;
  localparam logic [RECT_W-1:0] CFG_HEIGHT_RESET = 13'd480;

  // result item kinds
  localparam logic KIND_RUN     = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [RECT_W-1:0]  BOX_SENTINEL = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;

  // one queued event: a closed run, a frame end, or both
  typedef struct packed {
    logic              has_run;
    logic              has_sum;
    logic [RECT_W-1:0] left;
    logic [RECT_W-1:0] top;
    logic [RECT_W-1:0] right;
  } amre_evt_t;

endpackage

// ----- rtl/amre_front.sv -----
// Front end: accepts pixels, tracks column/row and open run, classifies events.
// Depends on amre_pkg; pushes events into amre_queue.
`timescale 1ns / 1ps

module amre_front #(
  parameter int MAX_DIM = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [amre_pkg::RECT_W-1:0]   image_width,
  input  logic [amre_pkg::RECT_W-1:0]   image_height,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [amre_pkg::ALPHA_W-1:0]  in_pixel_alpha,
  input  logic                          q_full,
  output logic                          q_push,
  output amre_pkg::amre_evt_t           q_data
);
  import amre_pkg::*;

  localparam int CW = $clog2(MAX_DIM);
  localparam int XW = CW + 1;

  function automatic logic [XW-1:0] clamp_dim(input logic [RECT_W-1:0] v);
    if (v == '0) begin
      return XW'(1);
    end else if (32'(v) > MAX_DIM) begin
      return XW'(MAX_DIM);
    end else begin
      return XW'(v);
    end
  endfunction

  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] row_r, row_nxt;
  logic          open_r, open_nxt;
  logic [CW-1:0] start_r, start_nxt;

  logic [XW-1:0] w, h, col_inc, row_inc;
  logic          accept, opaque, last_col, last_row;
  logic [CW-1:0] run_left;

  assign w        = clamp_dim(image_width);
  assign h        = clamp_dim(image_height);
  assign col_inc  = {1'b0, col_r} + XW'(1);
  assign row_inc  = {1'b0, row_r} + XW'(1);
  assign last_col = col_inc >= w;
  assign last_row = row_inc >= h;
  assign opaque   = in_pixel_alpha != '0;
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign run_left = open_r ? start_r : col_r;

  always_comb begin
    q_data         = '0;
    q_data.top     = RECT_W'(row_r);
    q_data.left    = RECT_W'(run_left);
    q_data.has_sum = last_col && last_row;
    if (opaque) begin
      q_data.has_run = last_col;
      q_data.right   = RECT_W'(col_inc);
    end else begin
      q_data.has_run = open_r;
      q_data.left    = RECT_W'(start_r);
      q_data.right   = RECT_W'(col_r);
    end
  end

  assign q_push = accept && (q_data.has_run || q_data.has_sum);

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    open_nxt  = open_r;
    start_nxt = start_r;
    if (accept) begin
      if (last_col && last_row) begin
        col_nxt   = '0;
        row_nxt   = '0;
        open_nxt  = 1'b0;
        start_nxt = '0;
      end else if (last_col) begin
        col_nxt  = '0;
        row_nxt  = CW'(row_inc);
        open_nxt = 1'b0;
        if (opaque && !open_r) begin
          start_nxt = col_r;
        end
      end else begin
        col_nxt   = CW'(col_inc);
        open_nxt  = opaque;
        start_nxt = run_left;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      open_r  <= 1'b0;
      start_r <= '0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      open_r  <= open_nxt;
      start_r <= start_nxt;
    end
  end

endmodule

// ----- rtl/amre_queue.sv -----
// Short event queue between front and back ends.
// Depends on amre_pkg for the event type and depth.
`timescale 1ns / 1ps

module amre_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  amre_pkg::amre_evt_t push_data,
  input  logic                pop,
  output amre_pkg::amre_evt_t head,
  output logic                full,
  output logic                empty
);
  import amre_pkg::*;

  amre_evt_t            slot_r [QDEPTH];
  logic [QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]      count_r, count_nxt;
  logic                 do_pop;

  assign full   = count_r == (QPTR_W + 1)'(QDEPTH);
  assign empty  = count_r == '0;
  assign head   = slot_r[rd_ptr_r];
  assign do_pop = pop && !empty;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + (QPTR_W + 1)'(1);
    end else if (!push && do_pop) begin
      count_nxt = count_r - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- rtl/amre_back.sv -----
// Back end: keeps bounding box and run count, formats result items.
// Depends on amre_pkg; pops events from amre_queue.
`timescale 1ns / 1ps

module amre_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  amre_pkg::amre_evt_t           q_head,
  input  logic                          q_empty,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_item_kind,
  output logic [amre_pkg::RECT_W-1:0]   out_rect_left,
  output logic [amre_pkg::RECT_W-1:0]   out_rect_top,
  output logic [amre_pkg::RECT_W-1:0]   out_rect_right,
  output logic [amre_pkg::RECT_W-1:0]   out_rect_bottom,
  output logic [amre_pkg::COUNT_W-1:0]  out_run_total,
  output logic                          out_frame_empty,
  output logic                          out_frame_last
);
  import amre_pkg::*;

  logic [RECT_W-1:0]  box_l_r, box_l_nxt, box_t_r, box_t_nxt;
  logic [RECT_W-1:0]  box_r_r, box_r_nxt, box_b_r, box_b_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt, count_inc;
  logic               sum_pend_r, sum_pend_nxt;
  logic               valid_r, valid_nxt;
  logic               kind_r, kind_nxt, empty_r, empty_nxt, last_r, last_nxt;
  logic [RECT_W-1:0]  l_r, l_nxt, t_r, t_nxt, rr_r, rr_nxt, b_r, b_nxt;
  logic [COUNT_W-1:0] total_r, total_nxt;
  logic [RECT_W-1:0]  run_bottom;
  logic               load, emit_sum;

  assign load       = !valid_r || out_ready;
  assign count_inc  = (count_r != COUNT_MAX) ? count_r + COUNT_W'(1) : count_r;
  assign run_bottom = q_head.top + RECT_W'(1);

  always_comb begin
    box_l_nxt    = box_l_r;
    box_t_nxt    = box_t_r;
    box_r_nxt    = box_r_r;
    box_b_nxt    = box_b_r;
    count_nxt    = count_r;
    sum_pend_nxt = sum_pend_r;
    valid_nxt    = valid_r && !out_ready;
    kind_nxt     = kind_r;
    l_nxt        = l_r;
    t_nxt        = t_r;
    rr_nxt       = rr_r;
    b_nxt        = b_r;
    total_nxt    = total_r;
    empty_nxt    = empty_r;
    last_nxt     = last_r;
    q_pop        = 1'b0;
    emit_sum     = 1'b0;

    if (load && sum_pend_r) begin
      emit_sum     = 1'b1;
      sum_pend_nxt = 1'b0;
      q_pop        = 1'b1;
    end else if (load && !q_empty) begin
      if (q_head.has_run) begin
        // emit the run and fold it into the box
        valid_nxt = 1'b1;
        kind_nxt  = KIND_RUN;
        l_nxt     = q_head.left;
        t_nxt     = q_head.top;
        rr_nxt    = q_head.right;
        b_nxt     = run_bottom;
        total_nxt = count_inc;
        empty_nxt = 1'b0;
        last_nxt  = 1'b0;
        count_nxt = count_inc;
        if (q_head.left < box_l_r) box_l_nxt = q_head.left;
        if (q_head.top < box_t_r) box_t_nxt = q_head.top;
        if (q_head.right > box_r_r) box_r_nxt = q_head.right;
        if (run_bottom > box_b_r) box_b_nxt = run_bottom;
        if (q_head.has_sum) begin
          sum_pend_nxt = 1'b1;
        end else begin
          q_pop = 1'b1;
        end
      end else begin
        emit_sum = 1'b1;
        q_pop    = 1'b1;
      end
    end

    if (emit_sum) begin
      valid_nxt = 1'b1;
      kind_nxt  = KIND_SUMMARY;
      last_nxt  = 1'b1;
      if (count_r == '0) begin
        l_nxt     = '0;
        t_nxt     = '0;
        rr_nxt    = '0;
        b_nxt     = '0;
        total_nxt = '0;
        empty_nxt = 1'b1;
      end else begin
        l_nxt     = box_l_r;
        t_nxt     = box_t_r;
        rr_nxt    = box_r_r;
        b_nxt     = box_b_r;
        total_nxt = count_r;
        empty_nxt = 1'b0;
      end
      // drop frame state for the next frame
      box_l_nxt = BOX_SENTINEL;
      box_t_nxt = BOX_SENTINEL;
      box_r_nxt = '0;
      box_b_nxt = '0;
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_l_r    <= BOX_SENTINEL;
      box_t_r    <= BOX_SENTINEL;
      box_r_r    <= '0;
      box_b_r    <= '0;
      count_r    <= '0;
      sum_pend_r <= 1'b0;
      valid_r    <= 1'b0;
    end else begin
      box_l_r    <= box_l_nxt;
      box_t_r    <= box_t_nxt;
      box_r_r    <= box_r_nxt;
      box_b_r    <= box_b_nxt;
      count_r    <= count_nxt;
      sum_pend_r <= sum_pend_nxt;
      valid_r    <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    l_r     <= l_nxt;
    t_r     <= t_nxt;
    rr_r    <= rr_nxt;
    b_r     <= b_nxt;
    total_r <= total_nxt;
    empty_r <= empty_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid       = valid_r;
  assign out_item_kind   = kind_r;
  assign out_rect_left   = l_r;
  assign out_rect_top    = t_r;
  assign out_rect_right  = rr_r;
  assign out_rect_bottom = b_r;
  assign out_run_total   = total_r;
  assign out_frame_empty = empty_r;
  assign out_frame_last  = last_r;

endmodule

// ----- rtl/alpha_mask_run_extractor_unit.sv -----
// Top level of the alpha mask run extractor: config registers, front, queue, back.
// Depends on amre_pkg, amre_front, amre_queue and amre_back.
`timescale 1ns / 1ps

//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------
//  in      | input     | in_valid / in_ready  | in_pixel_alpha
//  out     | output    | out_valid / out_ready| kind, rect l/t/r/b, run_total, flags
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  One pixel is taken per cycle while in_ready is high. Its event is written to
//  the queue at the transfer edge and the result enters the output register at the
//  next edge when the output is free. The back end delivers one result per cycle
//  unless out_ready stalls it; a frame end that also closes a run gives a run item
//  and then a summary. The four-entry event queue absorbs output stalls; in_ready
//  drops only when it fills. Synchronous active-low reset clears all frame state;
//  configuration is always ready and applies from the next pixel on.

module alpha_mask_run_extractor_unit #(
  parameter int MAX_DIM = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [amre_pkg::ALPHA_W-1:0]   in_pixel_alpha,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_item_kind,
  output logic [amre_pkg::RECT_W-1:0]    out_rect_left,
  output logic [amre_pkg::RECT_W-1:0]    out_rect_top,
  output logic [amre_pkg::RECT_W-1:0]    out_rect_right,
  output logic [amre_pkg::RECT_W-1:0]    out_rect_bottom,
  output logic [amre_pkg::COUNT_W-1:0]   out_run_total,
  output logic                           out_frame_empty,
  output logic                           out_frame_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [amre_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [amre_pkg::RECT_W-1:0]    cfg_data
);
  import amre_pkg::*;

  logic [RECT_W-1:0] width_r, width_nxt, height_r, height_nxt;
  logic              q_push, q_pop, q_full, q_empty;
  amre_evt_t         q_wdata, q_head;

  assign cfg_ready = 1'b1;

  // write a known register; ignore indexes beyond the list
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  width_nxt  = cfg_data;
        CFG_IMAGE_HEIGHT: height_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_WIDTH_RESET;
      height_r <= CFG_HEIGHT_RESET;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  amre_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .image_width    (width_r),
    .image_height   (height_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_alpha (in_pixel_alpha),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_wdata)
  );

  amre_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  amre_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_head          (q_head),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_item_kind   (out_item_kind),
    .out_rect_left   (out_rect_left),
    .out_rect_top    (out_rect_top),
    .out_rect_right  (out_rect_right),
    .out_rect_bottom (out_rect_bottom),
    .out_run_total   (out_run_total),
    .out_frame_empty (out_frame_empty),
    .out_frame_last  (out_frame_last)
  );

endmodule

// ----- bench/alpha_mask_run_extractor_checker.sv -----
// Scoreboard for the alpha mask run extractor: predicts run and summary items
// from observed pixel and register transfers and checks every result transfer.
// Depends on amre_pkg only.
`timescale 1ns / 1ps

module alpha_mask_run_extractor_checker #(
  parameter int MAX_DIM = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [amre_pkg::ALPHA_W-1:0]   in_pixel_alpha,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           out_item_kind,
  input  logic [amre_pkg::RECT_W-1:0]    out_rect_left,
  input  logic [amre_pkg::RECT_W-1:0]    out_rect_top,
  input  logic [amre_pkg::RECT_W-1:0]    out_rect_right,
  input  logic [amre_pkg::RECT_W-1:0]    out_rect_bottom,
  input  logic [amre_pkg::COUNT_W-1:0]   out_run_total,
  input  logic                           out_frame_empty,
  input  logic                           out_frame_last,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [amre_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [amre_pkg::RECT_W-1:0]    cfg_data,
  output int                             fail_count,
  output int                             outstanding
);
  import amre_pkg::*;

  typedef struct packed {
    logic               kind;
    logic [RECT_W-1:0]  left;
    logic [RECT_W-1:0]  top;
    logic [RECT_W-1:0]  right;
    logic [RECT_W-1:0]  bottom;
    logic [COUNT_W-1:0] total;
    logic               empty;
    logic               last;
  } rect_item_t;

  rect_item_t pending_rects[$];

  logic [RECT_W-1:0]  width_reg;
  logic [RECT_W-1:0]  height_reg;
  logic [11:0]        col_pos;
  logic [11:0]        row_pos;
  logic               run_active;
  logic [11:0]        run_left;
  logic [RECT_W-1:0]  bbox_l;
  logic [RECT_W-1:0]  bbox_t;
  logic [RECT_W-1:0]  bbox_r;
  logic [RECT_W-1:0]  bbox_b;
  logic [COUNT_W-1:0] run_tally;

  initial fail_count = 0;
  initial outstanding = 0;

  function automatic logic [RECT_W-1:0] clamp_extent(input logic [RECT_W-1:0] v);
    logic [RECT_W-1:0] r;
    r = v;
    if (v == '0) r = RECT_W'(1);
    else if (v > MAX_DIM) r = RECT_W'(MAX_DIM);
    return r;
  endfunction

  task automatic clear_frame_state();
    col_pos    = '0;
    row_pos    = '0;
    run_active = 1'b0;
    run_left   = '0;
    bbox_l     = BOX_SENTINEL;
    bbox_t     = BOX_SENTINEL;
    bbox_r     = '0;
    bbox_b     = '0;
    run_tally  = '0;
  endtask

  // Close the open run at exclusive column stop_col and queue its rectangle.
  task automatic close_run(input logic [RECT_W-1:0] stop_col);
    rect_item_t r;
    logic [RECT_W-1:0] row_ext;
    row_ext = {1'b0, row_pos};
    if (run_tally != COUNT_MAX) run_tally = run_tally + 1'b1;
    if ({1'b0, run_left} < bbox_l) bbox_l = {1'b0, run_left};
    if (row_ext < bbox_t) bbox_t = row_ext;
    if (stop_col > bbox_r) bbox_r = stop_col;
    if (row_ext + 13'd1 > bbox_b) bbox_b = row_ext + 13'd1;
    r.kind   = KIND_RUN;
    r.left   = {1'b0, run_left};
    r.top    = row_ext;
    r.right  = stop_col;
    r.bottom = row_ext + 13'd1;
    r.total  = run_tally;
    r.empty  = 1'b0;
    r.last   = 1'b0;
    pending_rects.push_back(r);
    run_active = 1'b0;
  endtask

  task automatic predict_pixel(input logic [ALPHA_W-1:0] alpha);
    rect_item_t s;
    logic [RECT_W-1:0] col_ext;
    logic at_col_end;
    logic at_row_end;
    col_ext    = {1'b0, col_pos};
    at_col_end = (col_ext + 13'd1) >= clamp_extent(width_reg);
    at_row_end = ({1'b0, row_pos} + 13'd1) >= clamp_extent(height_reg);
    if (alpha != '0) begin
      if (!run_active) begin
        run_active = 1'b1;
        run_left   = col_pos;
      end
      if (at_col_end) close_run(col_ext + 13'd1);
    end else if (run_active) begin
      close_run(col_ext);
    end
    if (at_col_end && at_row_end) begin
      s = '0;
      s.kind = KIND_SUMMARY;
      s.last = 1'b1;
      if (run_tally == '0) begin
        s.empty = 1'b1;
      end else begin
        s.left   = bbox_l;
        s.top    = bbox_t;
        s.right  = bbox_r;
        s.bottom = bbox_b;
        s.total  = run_tally;
      end
      pending_rects.push_back(s);
      clear_frame_state();
    end else if (at_col_end) begin
      col_pos    = '0;
      row_pos    = row_pos + 1'b1;
      run_active = 1'b0;
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endtask

  task automatic check_result();
    rect_item_t want;
    rect_item_t got;
    got.kind   = out_item_kind;
    got.left   = out_rect_left;
    got.top    = out_rect_top;
    got.right  = out_rect_right;
    got.bottom = out_rect_bottom;
    got.total  = out_run_total;
    got.empty  = out_frame_empty;
    got.last   = out_frame_last;
    if (pending_rects.size() == 0) begin
      if (fail_count < 10)
        $display("unexpected result: kind %0d l %0d t %0d r %0d b %0d n %0d e %0d f %0d",
                 got.kind, got.left, got.top, got.right, got.bottom, got.total,
                 got.empty, got.last);
      fail_count++;
    end else begin
      want = pending_rects.pop_front();
      if (want.kind !== got.kind || want.left !== got.left || want.top !== got.top ||
          want.right !== got.right || want.bottom !== got.bottom ||
          want.total !== got.total || want.empty !== got.empty ||
          want.last !== got.last) begin
        if (fail_count < 10) begin
          $display("mismatch exp: kind %0d l %0d t %0d r %0d b %0d n %0d e %0d f %0d",
                   want.kind, want.left, want.top, want.right, want.bottom, want.total,
                   want.empty, want.last);
          $display("         got: kind %0d l %0d t %0d r %0d b %0d n %0d e %0d f %0d",
                   got.kind, got.left, got.top, got.right, got.bottom, got.total,
                   got.empty, got.last);
        end
        fail_count++;
      end
    end
  endtask

  // Pixel first: a register write in the same cycle only affects later pixels.
  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = CFG_WIDTH_RESET;
      height_reg = CFG_HEIGHT_RESET;
      clear_frame_state();
      pending_rects.delete();
    end else begin
      if (in_valid && in_ready) predict_pixel(in_pixel_alpha);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:  width_reg = cfg_data;
          CFG_IMAGE_HEIGHT: height_reg = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) check_result();
    end
    outstanding <= pending_rects.size();
  end

endmodule

// ----- bench/alpha_mask_run_extractor_unit_tb.sv -----
// Top of the alpha mask run extractor bench: clock, reset, pixel and register
// stimulus, random output backpressure and the final verdict.
// Depends on amre_pkg, alpha_mask_run_extractor_unit and the checker module.
`timescale 1ns / 1ps

module alpha_mask_run_extractor_unit_tb;
  import amre_pkg::*;

  localparam int DIM_CAP    = 4096;
  localparam int IDLE_PCT   = 22;
  localparam int SETTLE     = 6;
  localparam int RAND_PIXELS = 400;

  // indexes past the register file; writes to them must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [ALPHA_W-1:0]   in_pixel_alpha = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_item_kind;
  logic [RECT_W-1:0]    out_rect_left;
  logic [RECT_W-1:0]    out_rect_top;
  logic [RECT_W-1:0]    out_rect_right;
  logic [RECT_W-1:0]    out_rect_bottom;
  logic [COUNT_W-1:0]   out_run_total;
  logic                 out_frame_empty;
  logic                 out_frame_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [RECT_W-1:0]    cfg_data = '0;

  int mismatches;
  int outstanding;

  // no idling on either side while steady is set
  logic steady = 1'b0;
  // current opacity of the generated scanline; toggles to form runs
  logic opaque_now = 1'b0;
  int   pixels_sent = 0;

  alpha_mask_run_extractor_unit #(
    .MAX_DIM(DIM_CAP)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pixel_alpha  (in_pixel_alpha),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_item_kind   (out_item_kind),
    .out_rect_left   (out_rect_left),
    .out_rect_top    (out_rect_top),
    .out_rect_right  (out_rect_right),
    .out_rect_bottom (out_rect_bottom),
    .out_run_total   (out_run_total),
    .out_frame_empty (out_frame_empty),
    .out_frame_last  (out_frame_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  alpha_mask_run_extractor_checker #(
    .MAX_DIM(DIM_CAP)
  ) rect_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pixel_alpha  (in_pixel_alpha),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_item_kind   (out_item_kind),
    .out_rect_left   (out_rect_left),
    .out_rect_top    (out_rect_top),
    .out_rect_right  (out_rect_right),
    .out_rect_bottom (out_rect_bottom),
    .out_run_total   (out_run_total),
    .out_frame_empty (out_frame_empty),
    .out_frame_last  (out_frame_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (mismatches),
    .outstanding     (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  // Result side: stall at random unless the steady stretch is on.
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Offer one pixel and hold it until the transfer. Valid is not dropped here,
  // so back-to-back pixels never lower and raise it in the same step; an idle
  // gap, a drain or the next call decides what happens after the transfer.
  task automatic send_pixel(input logic [ALPHA_W-1:0] alpha);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel_alpha <= alpha;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixels_sent++;
  endtask

  // Register write; drop valid after the transfer.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RECT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold the pixel stream until every predicted result has come out, then
  // give pixels that close nothing time to clear the pipeline.
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Scanline generator: opacity toggles with flip_pct percent per pixel to
  // form runs of random length, with an occasional raw byte as noise.
  task automatic feed_pixels(input int count, input int flip_pct);
    logic [ALPHA_W-1:0] a;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < flip_pct) opaque_now = !opaque_now;
      a = opaque_now ? ALPHA_W'($urandom_range(1, 255)) : '0;
      if ($urandom_range(19) == 0) a = ALPHA_W'($urandom_range(0, 255));
      send_pixel(a);
    end
  endtask

  initial begin
    int frame_count;
    int frame_px;
    int flip;
    int part;
    logic need_cfg;
    logic [RECT_W-1:0] w_val;
    logic [RECT_W-1:0] h_val;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---
    // Reset dimensions: a one-pixel run closed by a zero, then leave a run open.
    send_pixel(8'hFF);
    send_pixel(8'h00);
    send_pixel(8'h01);
    send_pixel(8'h80);
    wait_drain();

    // Zero dimensions act as one. The column counter is past the new last
    // column, so the next pixel closes the open run and ends the frame.
    write_reg(CFG_IMAGE_WIDTH, '0);
    write_reg(CFG_IMAGE_HEIGHT, '0);
    send_pixel(8'h00);
    // 1x1 frames: run at the last pixel (run then summary), an empty frame, then two more run frames.
    send_pixel(8'h7F);
    send_pixel(8'h00);
    send_pixel(8'h55);
    send_pixel(8'hAA);
    wait_drain();

    // Writes to unused indexes must be dropped: still a 1x1 empty frame.
    write_reg(CFG_SPARE_A, '1);
    write_reg(CFG_SPARE_B, '0);
    send_pixel(8'h00);
    wait_drain();

    // 4x2 frame: a run reaching the row end, then two short runs.
    write_reg(CFG_IMAGE_WIDTH, 13'd4);
    write_reg(CFG_IMAGE_HEIGHT, 13'd2);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'hFF);
    send_pixel(8'hFF);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    wait_drain();

    // Largest width and oversized height, then shrink both mid-frame.
    write_reg(CFG_IMAGE_WIDTH, 13'd4096);
    write_reg(CFG_IMAGE_HEIGHT, '1);
    send_pixel(8'hFF);
    send_pixel(8'hFF);
    send_pixel(8'hFF);
    wait_drain();
    write_reg(CFG_IMAGE_WIDTH, 13'd2);
    write_reg(CFG_IMAGE_HEIGHT, 13'd1);
    send_pixel(8'h00);
    wait_drain();

    // --- random part: small frames streamed back to back ---
    frame_count = 0;
    need_cfg    = 1'b1;
    w_val       = 13'd1;
    h_val       = 13'd1;
    part        = pixels_sent;
    while (pixels_sent - part < RAND_PIXELS) begin
      // a quiet stretch with no idling on either side
      steady = (frame_count >= 6 && frame_count < 14);
      if (need_cfg || $urandom_range(2) == 0) begin
        wait_drain();
        case ($urandom_range(9))
          0:       w_val = '0;
          1:       w_val = RECT_W'($urandom_range(13, 40));
          default: w_val = RECT_W'($urandom_range(1, 12));
        endcase
        h_val = ($urandom_range(9) == 0) ? '0 : RECT_W'($urandom_range(1, 5));
        write_reg(CFG_IMAGE_WIDTH, w_val);
        write_reg(CFG_IMAGE_HEIGHT, h_val);
        need_cfg = 1'b0;
      end
      frame_px = ((w_val == '0) ? 1 : int'(w_val)) * ((h_val == '0) ? 1 : int'(h_val));
      case ($urandom_range(3))
        0:       flip = 0;
        1:       flip = 10;
        2:       flip = 30;
        default: flip = 60;
      endcase
      opaque_now = 1'($urandom_range(1));
      if ($urandom_range(7) == 0) begin
        // Break the frame: change size mid-frame, go on a little, then
        // realign with a 1x1 frame, which always clears the counters.
        feed_pixels($urandom_range(1, frame_px), flip);
        wait_drain();
        write_reg(CFG_IMAGE_WIDTH, RECT_W'($urandom_range(1, 6)));
        write_reg(CFG_IMAGE_HEIGHT, RECT_W'($urandom_range(1, 3)));
        feed_pixels($urandom_range(1, 8), flip);
        wait_drain();
        write_reg(CFG_IMAGE_WIDTH, 13'd1);
        write_reg(CFG_IMAGE_HEIGHT, 13'd1);
        send_pixel(ALPHA_W'($urandom_range(0, 255)));
        need_cfg = 1'b1;
      end else begin
        feed_pixels(frame_px, flip);
      end
      frame_count++;
    end
    steady = 1'b0;

    // Oversized width clamps to the maximum: a few runs in a long row, then
    // shrink the width so the column counter sits past the last column and
    // the next opaque pixel closes its run and ends the frame.
    wait_drain();
    write_reg(CFG_IMAGE_WIDTH, '1);
    write_reg(CFG_IMAGE_HEIGHT, 13'd1);
    opaque_now = 1'b1;
    feed_pixels(6, 5);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    wait_drain();
    write_reg(CFG_IMAGE_WIDTH, 13'd1);
    send_pixel(8'hFF);

    wait_drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
